// ----- rtl/cnfsa_pkg.sv -----
// Shared constants, types and helper functions of the slot allocator.
`default_nettype none

package cnfsa_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_W    = 11;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int ROWS      = MAX_SLOTS / WORD_W;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int ROWC_W    = ROW_W + 1;
    localparam int IDX_W     = $clog2(MAX_SLOTS);

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEEK   = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_RESULT = 5'b01000,
        ST_REL    = 5'b10000
    } state_t;

    function automatic logic [BIT_W-1:0] first_word_bit(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] first_row(input logic [ROWS-1:0] v);
        logic [ROW_W-1:0] r;
        r = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (v[i])
            begin
                r = ROW_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/circular_next_free_slot_allocator.sv -----
// Allocate: after accept, seek and row read/check repeat until a free slot is found or none is left,
// then the result is registered out; the wrap to slot 1 adds a seek step (at most 3 row reads).
// Release: read, then write back of the row, no result. One transaction at a time; the row
// read/check loop over the single memory port and the per-row full summary set the rate.
// Reset: all slots free (row valid bits cleared), slot count 1024, output empty.
`default_nettype none

module circular_next_free_slot_allocator (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [cnfsa_pkg::SLOT_W-1:0] cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         command,
    input  wire logic [cnfsa_pkg::SLOT_W-1:0] slot,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [cnfsa_pkg::SLOT_W-1:0] granted_slot,
    output logic                              all_full
);
    import cnfsa_pkg::*;

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     count_reg;
    logic                  phase_reg, phase_next;
    logic [IDX_W-1:0]      start_reg, start_next;
    logic [IDX_W-1:0]      lo_reg, lo_next;
    logic [IDX_W-1:0]      hm1_reg, hm1_next;
    logic [ROWC_W-1:0]     cur_row_reg, cur_row_next;
    logic [IDX_W-1:0]      rel_idx_reg, rel_idx_next;
    logic [ROWS-1:0]       full_reg, full_next;
    logic [ROWS-1:0]       rvalid_reg, rvalid_next;
    logic                  rd_ok_reg, rd_ok_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;
    logic                  res_full_reg, res_full_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic                  out_full_reg, out_full_next;

    logic [WORD_W-1:0]     mem [ROWS];
    logic [WORD_W-1:0]     rd_data_reg;
    logic                  mem_re, mem_we;
    logic [ROW_W-1:0]      mem_raddr, mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;

    logic [SLOT_W-1:0]     cnt_eff;
    logic                  start_ok, rel_ok;
    logic [IDX_W-1:0]      s_idx, rel_idx;
    logic [ROW_W-1:0]      last_row, lo_row, row;
    logic [ROWS-1:0]       cand;
    logic [ROW_W-1:0]      cand_row;
    logic [WORD_W-1:0]     row_data, lo_mask, hi_mask, free_bits, new_row;
    logic [BIT_W-1:0]      hit_bit, rel_bit;

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign granted_slot = out_slot_reg;
    assign all_full     = out_full_reg;

    assign cnt_eff  = (count_reg > SLOT_W'(MAX_SLOTS)) ? SLOT_W'(MAX_SLOTS) : count_reg;
    assign start_ok = (slot != '0) && (slot <= cnt_eff);
    assign s_idx    = start_ok ? IDX_W'(slot - SLOT_W'(1)) : '0;
    assign rel_ok   = (slot != '0) && (slot <= SLOT_W'(MAX_SLOTS));
    assign rel_idx  = IDX_W'(slot - SLOT_W'(1));
    assign rel_bit  = rel_idx_reg[BIT_W-1:0];

    assign last_row = hm1_reg[IDX_W-1:BIT_W];
    assign lo_row   = lo_reg[IDX_W-1:BIT_W];
    assign row      = cur_row_reg[ROW_W-1:0];

    always_comb
    begin
        for (int r = 0; r < ROWS; r++) begin
            cand[r] = !full_reg[r] && (ROWC_W'(r) >= cur_row_reg)
                      && (ROW_W'(r) <= last_row);
        end
    end

    assign cand_row  = first_row(cand);
    assign row_data  = rd_ok_reg ? rd_data_reg : '0;
    assign lo_mask   = (row == lo_row) ? ({WORD_W{1'b1}} << lo_reg[BIT_W-1:0])
                                       : {WORD_W{1'b1}};
    assign hi_mask   = (row == last_row)
                       ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hm1_reg[BIT_W-1:0]))
                       : {WORD_W{1'b1}};
    assign free_bits = ~row_data & lo_mask & hi_mask;
    assign hit_bit   = first_word_bit(free_bits);
    assign new_row   = row_data | (WORD_W'(1) << hit_bit);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        start_next     = start_reg;
        lo_next        = lo_reg;
        hm1_next       = hm1_reg;
        cur_row_next   = cur_row_reg;
        rel_idx_next   = rel_idx_reg;
        full_next      = full_reg;
        rvalid_next    = rvalid_reg;
        rd_ok_next     = rd_ok_reg;
        res_slot_next  = res_slot_reg;
        res_full_next  = res_full_reg;
        out_valid_next = out_valid_reg;
        out_slot_next  = out_slot_reg;
        out_full_next  = out_full_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        mem_we         = 1'b0;
        mem_waddr      = row;
        mem_wdata      = new_row;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_RELEASE)
                    begin
                        if (rel_ok)
                        begin
                            mem_re       = 1'b1;
                            mem_raddr    = rel_idx[IDX_W-1:BIT_W];
                            rel_idx_next = rel_idx;
                            state_next   = ST_REL;
                        end
                    end
                    else if (cnt_eff == '0)
                    begin
                        res_slot_next = '0;
                        res_full_next = 1'b1;
                        state_next    = ST_RESULT;
                    end
                    else
                    begin
                        phase_next   = 1'b0;
                        start_next   = s_idx;
                        lo_next      = s_idx;
                        hm1_next     = IDX_W'(cnt_eff - SLOT_W'(1));
                        cur_row_next = ROWC_W'(s_idx[IDX_W-1:BIT_W]);
                        state_next   = ST_SEEK;
                    end
                end
            end
            ST_SEEK:
            begin
                if (|cand)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = cand_row;
                    cur_row_next = ROWC_W'(cand_row);
                    state_next   = ST_CHECK;
                end
                else if (!phase_reg && (start_reg != '0))
                begin
                    phase_next   = 1'b1;
                    lo_next      = '0;
                    hm1_next     = start_reg - IDX_W'(1);
                    cur_row_next = '0;
                end
                else
                begin
                    res_slot_next = '0;
                    res_full_next = 1'b1;
                    state_next    = ST_RESULT;
                end
            end
            ST_CHECK:
            begin
                if (|free_bits)
                begin
                    mem_we             = 1'b1;
                    full_next[row]     = &new_row;
                    rvalid_next[row]   = 1'b1;
                    res_slot_next      = SLOT_W'({row, hit_bit}) + SLOT_W'(1);
                    res_full_next      = 1'b0;
                    state_next         = ST_RESULT;
                end
                else
                begin
                    cur_row_next = cur_row_reg + ROWC_W'(1);
                    state_next   = ST_SEEK;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = res_slot_reg;
                    out_full_next  = res_full_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_REL:
            begin
                mem_we                                 = 1'b1;
                mem_waddr                              = rel_idx_reg[IDX_W-1:BIT_W];
                mem_wdata                              = row_data & ~(WORD_W'(1) << rel_bit);
                full_next[rel_idx_reg[IDX_W-1:BIT_W]]   = 1'b0;
                rvalid_next[rel_idx_reg[IDX_W-1:BIT_W]] = 1'b1;
                state_next                             = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (mem_re)
        begin
            rd_ok_next = rvalid_reg[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= SLOT_W'(MAX_SLOTS);
            full_reg      <= '0;
            rvalid_reg    <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            full_reg      <= full_next;
            rvalid_reg    <= rvalid_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg    <= phase_next;
        start_reg    <= start_next;
        lo_reg       <= lo_next;
        hm1_reg      <= hm1_next;
        cur_row_reg  <= cur_row_next;
        rel_idx_reg  <= rel_idx_next;
        res_slot_reg <= res_slot_next;
        res_full_reg <= res_full_next;
        out_slot_reg <= out_slot_next;
        out_full_reg <= out_full_next;
    end

endmodule

`default_nettype wire

// ----- rtl/cnfsa_checker.sv -----
// Port-level checker of the slot allocator and its bind to the top level.
`default_nettype none

module cnfsa_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         command,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [cnfsa_pkg::SLOT_W-1:0] granted_slot,
    input wire logic                         all_full
);
    import cnfsa_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(granted_slot) && $stable(all_full))
        else $error("result changed while stalled");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && all_full |-> granted_slot == '0)
        else $error("full result with non-zero slot");

    a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !all_full |-> granted_slot != '0 && granted_slot <= SLOT_W'(MAX_SLOTS))
        else $error("granted slot out of range");

    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_ALLOC |=> !in_ready)
        else $error("allocate transaction did not hold off input");

endmodule

bind circular_next_free_slot_allocator cnfsa_checker u_cnfsa_checker (.*);

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the circular next-free slot allocator.
`timescale 1ns / 1ps

module tb_top;
    import cnfsa_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_TICKS = 20;
    localparam int SEGMENTS     = 12;
    localparam int SEG_ITEMS    = 90;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              full;
    } grant_t;

    class grant_scoreboard;
        bit                taken [MAX_SLOTS];
        logic [SLOT_W-1:0] count_reg;
        grant_t            grants_due [$];
        int                errors;

        function new();
            count_reg = SLOT_W'(MAX_SLOTS);
            errors    = 0;
        endfunction

        function void set_count(logic [SLOT_W-1:0] v);
            count_reg = v;
        endfunction

        function int usable();
            return (count_reg > MAX_SLOTS) ? MAX_SLOTS : int'(count_reg);
        endfunction

        function int pending();
            return grants_due.size();
        endfunction

        function grant_t find_free_slot(logic [SLOT_W-1:0] start_req);
            int     span;
            int     first;
            int     probe;
            grant_t g;
            g.slot = '0;
            g.full = 1'b1;
            span = usable();
            if (span == 0)
            begin
                return g;
            end
            first = (start_req >= 1 && start_req <= span) ? int'(start_req) : 1;
            for (int i = 0; i < span; i++)
            begin
                probe = (first - 1 + i) % span + 1;
                if (!taken[probe - 1])
                begin
                    g.slot = SLOT_W'(probe);
                    g.full = 1'b0;
                    return g;
                end
            end
            return g;
        endfunction

        function void note_request(logic cmd, logic [SLOT_W-1:0] s);
            grant_t g;
            if (cmd == CMD_RELEASE)
            begin
                if (s >= 1 && s <= MAX_SLOTS)
                begin
                    taken[s - 1] = 1'b0;
                end
            end
            else
            begin
                g = find_free_slot(s);
                if (!g.full)
                begin
                    taken[g.slot - 1] = 1'b1;
                end
                grants_due.push_back(g);
            end
        endfunction

        function void check_grant(logic [SLOT_W-1:0] got_slot, logic got_full);
            grant_t want;
            if (grants_due.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual granted_slot %0d all_full %0d",
                         $time, got_slot, got_full);
                errors++;
                return;
            end
            want = grants_due.pop_front();
            if (got_slot !== want.slot)
            begin
                $display("%0t: granted_slot expected %0d actual %0d", $time, want.slot, got_slot);
                errors++;
            end
            if (got_full !== want.full)
            begin
                $display("%0t: all_full expected %0d actual %0d", $time, want.full, got_full);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [SLOT_W-1:0] cfg_wr_data;
    logic              in_valid;
    logic              in_ready;
    logic              command;
    logic [SLOT_W-1:0] slot;
    logic              out_valid;
    logic              out_ready;
    logic [SLOT_W-1:0] granted_slot;
    logic              all_full;

    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;

    grant_scoreboard sb = new();

    circular_next_free_slot_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .slot         (slot),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted_slot (granted_slot),
        .all_full     (all_full)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_grant(granted_slot, all_full);
            end
            if (in_valid && in_ready)
            begin
                sb.note_request(command, slot);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic set_mode(input int mode);
        case (mode)
            1:       begin idle_pct = 86; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 86; end
            3:       begin idle_pct = 19; stall_pct = 19; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic send_request(input logic cmd, input logic [SLOT_W-1:0] s);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        slot     <= s;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_count(input logic [SLOT_W-1:0] v);
        drain();
        repeat (SETTLE_TICKS) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_count(v);
    endtask

    task automatic run_random(input int n_items);
        int                span;
        int                pick;
        logic              cmd;
        logic [SLOT_W-1:0] s;
        for (int k = 0; k < n_items; k++)
        begin
            span = sb.usable();
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                s = SLOT_W'($urandom_range(2047));
            end
            else
            begin
                s = SLOT_W'($urandom_range(span + 1, 1));
            end
            cmd = ($urandom_range(99) < 58) ? CMD_ALLOC : CMD_RELEASE;
            send_request(cmd, s);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        command     = CMD_ALLOC;
        slot        = '0;
        out_ready   = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_mode(0);
        send_request(CMD_ALLOC, 11'd1);
        send_request(CMD_ALLOC, 11'd1);
        send_request(CMD_ALLOC, 11'd1024);
        send_request(CMD_ALLOC, 11'd1024);
        send_request(CMD_ALLOC, 11'd0);
        send_request(CMD_ALLOC, 11'd2047);
        send_request(CMD_RELEASE, 11'd2);
        send_request(CMD_ALLOC, 11'd1);
        send_request(CMD_RELEASE, 11'd0);
        send_request(CMD_RELEASE, 11'd2047);
        send_request(CMD_RELEASE, 11'd1025);
        send_request(CMD_RELEASE, 11'd6);
        send_request(CMD_RELEASE, 11'd1024);
        send_request(CMD_ALLOC, 11'd1023);
        write_count(11'd0);
        send_request(CMD_ALLOC, 11'd5);
        send_request(CMD_RELEASE, 11'd1);
        write_count(11'd2);
        send_request(CMD_ALLOC, 11'd2);
        send_request(CMD_ALLOC, 11'd1);
        send_request(CMD_ALLOC, 11'd2047);
        write_count(11'd2047);
        send_request(CMD_ALLOC, 11'd1);
        send_request(CMD_ALLOC, 11'd1030);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:       write_count(11'd5);
                1:       write_count(11'd1);
                2:       write_count(11'd1024);
                3:       write_count(11'd2047);
                4:       write_count(11'd33);
                5:       write_count(SLOT_W'($urandom_range(64, 1)));
                6:       write_count(11'd3);
                7:       write_count(SLOT_W'($urandom_range(2047)));
                8:       write_count(11'd2);
                9:       write_count(11'd12);
                10:      write_count(11'd1025);
                default: write_count(SLOT_W'($urandom_range(16, 1)));
            endcase
            set_mode(seg % 4);
            run_random(SEG_ITEMS);
        end

        drain();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cnfsa_pkg.sv
rtl/circular_next_free_slot_allocator.sv
rtl/cnfsa_checker.sv
sim/tb_top.sv
